/* hw/rtl/fcsg_pkg.sv */
// ----------------------------------------------------------------------------
// fcsg_pkg
// shared constants, types and width helpers for the filled circle span
// generator
// ----------------------------------------------------------------------------
package fcsg_pkg;

	localparam int unsigned COORD_BITS_DEF   = 13;
	localparam int unsigned MAX_DIAMETER_DEF = 62;

	localparam int unsigned CLIP_W     = 12;
	localparam int unsigned DIAM_W     = 6;
	localparam int unsigned WIDTH_W    = 6;
	localparam int unsigned MAX_SPANS  = 64;
	localparam int unsigned CNT_W      = $clog2(MAX_SPANS);
	localparam int unsigned APB_DATA_W = 32;
	localparam int unsigned APB_ADDR_W = 4;

	// decision variable constants of the midpoint loop
	localparam int unsigned DEC_START     = 3;
	localparam int unsigned DEC_STEP_FLAT = 6;
	localparam int unsigned DEC_STEP_DIAG = 10;

	localparam logic [CLIP_W-1:0] WIN_LEFT_RST   = 12'd0;
	localparam logic [CLIP_W-1:0] WIN_RIGHT_RST  = 12'd4095;
	localparam logic [CLIP_W-1:0] WIN_TOP_RST    = 12'd0;
	localparam logic [CLIP_W-1:0] WIN_BOTTOM_RST = 12'd4095;

	typedef enum logic [1:0] {
		REG_WIN_LEFT   = 2'd0,
		REG_WIN_RIGHT  = 2'd1,
		REG_WIN_TOP    = 2'd2,
		REG_WIN_BOTTOM = 2'd3
	} fcsg_reg_t;

	// add or subtract select for the two lanes of the shared unit
	typedef struct packed {
		logic sub0;
		logic sub1;
	} fcsg_op_t;

	// compare flags back from the shared unit
	typedef struct packed {
		logic lt0;
		logic gt1;
	} fcsg_flags_t;

	// span hand-over from the sequencer to the output register
	typedef struct packed {
		logic load;
		logic last;
	} fcsg_emit_t;

	// signed working width: holds a coordinate plus radius and any clip value
	function automatic int unsigned calc_width(input int unsigned coord_bits);
		return ((coord_bits > CLIP_W) ? coord_bits : CLIP_W) + 1;
	endfunction

	function automatic int unsigned out_width(input int unsigned coord_bits);
		return coord_bits + 1;
	endfunction

	function automatic int unsigned radius_width(input int unsigned max_d);
		return $clog2((max_d >> 1) + 1);
	endfunction

	function automatic int unsigned dsat_width(input int unsigned max_d);
		return (DIAM_W > $clog2(max_d + 1)) ? DIAM_W : $clog2(max_d + 1);
	endfunction

endpackage

/* hw/rtl/fcsg_circle_if.sv */
// ----------------------------------------------------------------------------
// fcsg_circle_if
// circle input channel: valid/ready handshake with center and diameter
// ----------------------------------------------------------------------------
interface fcsg_circle_if #(
	parameter int unsigned COORD_BITS = fcsg_pkg::COORD_BITS_DEF
);
	import fcsg_pkg::*;

	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] center_x;
	logic signed [COORD_BITS-1:0] center_y;
	logic [DIAM_W-1:0]            diameter;

	modport source (output valid, output center_x, output center_y, output diameter,
		input ready);
	modport sink (input valid, input center_x, input center_y, input diameter,
		output ready);
endinterface

/* hw/rtl/fcsg_span_if.sv */
// ----------------------------------------------------------------------------
// fcsg_span_if
// span output channel: valid/ready handshake with one horizontal span
// ----------------------------------------------------------------------------
interface fcsg_span_if #(
	parameter int unsigned COORD_BITS = fcsg_pkg::COORD_BITS_DEF
);
	import fcsg_pkg::*;

	localparam int unsigned OUT_W = out_width(COORD_BITS);

	logic                    valid;
	logic                    ready;
	logic signed [OUT_W-1:0] span_x;
	logic signed [OUT_W-1:0] span_y;
	logic [WIDTH_W-1:0]      span_width;
	logic                    last_span;

	modport source (output valid, output span_x, output span_y, output span_width,
		output last_span, input ready);
	modport sink (input valid, input span_x, input span_y, input span_width,
		input last_span, output ready);
endinterface

/* hw/rtl/fcsg_lane_unit.sv */
// ----------------------------------------------------------------------------
// fcsg_lane_unit
// shared two-lane add/subtract unit with signed compare, used for the clip
// tests and for every span coordinate
// ----------------------------------------------------------------------------
module fcsg_lane_unit #(
	parameter int unsigned COORD_BITS = fcsg_pkg::COORD_BITS_DEF
) (
	input  fcsg_pkg::fcsg_op_t                                   op,
	input  logic signed [fcsg_pkg::calc_width(COORD_BITS)-1:0]  a0,
	input  logic signed [fcsg_pkg::calc_width(COORD_BITS)-1:0]  b0,
	input  logic signed [fcsg_pkg::calc_width(COORD_BITS)-1:0]  c0,
	input  logic signed [fcsg_pkg::calc_width(COORD_BITS)-1:0]  a1,
	input  logic signed [fcsg_pkg::calc_width(COORD_BITS)-1:0]  b1,
	input  logic signed [fcsg_pkg::calc_width(COORD_BITS)-1:0]  c1,
	output logic signed [fcsg_pkg::calc_width(COORD_BITS)-1:0]  res0,
	output logic signed [fcsg_pkg::calc_width(COORD_BITS)-1:0]  res1,
	output fcsg_pkg::fcsg_flags_t                                flags
);
	import fcsg_pkg::*;

	assign res0 = op.sub0 ? (a0 - b0) : (a0 + b0);
	assign res1 = op.sub1 ? (a1 - b1) : (a1 + b1);

	// lane 0 checks the low bound, lane 1 the high bound
	assign flags.lt0 = (res0 < c0);
	assign flags.gt1 = (res1 > c1);
endmodule

/* hw/rtl/fcsg_seq.sv */
// ----------------------------------------------------------------------------
// fcsg_seq
// sequencer for the midpoint circle loop: clip test, then while the output slot is free one span per cycle
// ----------------------------------------------------------------------------
module fcsg_seq #(
	parameter int unsigned COORD_BITS   = fcsg_pkg::COORD_BITS_DEF,
	parameter int unsigned MAX_DIAMETER = fcsg_pkg::MAX_DIAMETER_DEF
) (
	input  logic                                                 clk,
	input  logic                                                 arst_n,
	input  logic                                                 start,
	output logic                                                 idle,
	input  logic signed [COORD_BITS-1:0]                         center_x,
	input  logic signed [COORD_BITS-1:0]                         center_y,
	input  logic [fcsg_pkg::DIAM_W-1:0]                          diameter,
	input  logic [fcsg_pkg::CLIP_W-1:0]                          win_left,
	input  logic [fcsg_pkg::CLIP_W-1:0]                          win_right,
	input  logic [fcsg_pkg::CLIP_W-1:0]                          win_top,
	input  logic [fcsg_pkg::CLIP_W-1:0]                          win_bottom,
	input  logic                                                 slot_free,
	output fcsg_pkg::fcsg_op_t                                   op,
	output logic signed [fcsg_pkg::calc_width(COORD_BITS)-1:0]  a0,
	output logic signed [fcsg_pkg::calc_width(COORD_BITS)-1:0]  b0,
	output logic signed [fcsg_pkg::calc_width(COORD_BITS)-1:0]  c0,
	output logic signed [fcsg_pkg::calc_width(COORD_BITS)-1:0]  a1,
	output logic signed [fcsg_pkg::calc_width(COORD_BITS)-1:0]  b1,
	output logic signed [fcsg_pkg::calc_width(COORD_BITS)-1:0]  c1,
	input  fcsg_pkg::fcsg_flags_t                                flags,
	output fcsg_pkg::fcsg_emit_t                                 emit,
	output logic [fcsg_pkg::WIDTH_W-1:0]                         span_width
);
	import fcsg_pkg::*;

	localparam int unsigned CALC_W = calc_width(COORD_BITS);
	localparam int unsigned R_W    = radius_width(MAX_DIAMETER);
	localparam int unsigned DS_W   = dsat_width(MAX_DIAMETER);
	localparam int unsigned DEC_W  = R_W + 5;

	typedef enum logic [8:0] {
		PH_IDLE   = 9'b000000001,
		PH_CHK_X  = 9'b000000010,
		PH_CHK_Y  = 9'b000000100,
		PH_LOOP_A = 9'b000001000,
		PH_LOOP_B = 9'b000010000,
		PH_LOOP_C = 9'b000100000,
		PH_LOOP_D = 9'b001000000,
		PH_TAIL_C = 9'b010000000,
		PH_TAIL_D = 9'b100000000
	} phase_t;

	phase_t                       phase_q, phase_d;
	logic [R_W-1:0]               col_q, col_d;
	logic [R_W-1:0]               row_q, row_d;
	logic signed [DEC_W-1:0]      dec_q, dec_d;
	logic signed [COORD_BITS-1:0] cx_q, cy_q;
	logic [CNT_W-1:0]             cnt_q;

	logic [DS_W-1:0]         diam_ext, dsat;
	logic [R_W-1:0]          r_init;
	logic signed [DEC_W-1:0] dec_init, dec_flat, dec_diag;
	logic [R_W:0]            col_p1, col_p2, row_ext;
	logic [R_W-1:0]          ofs;
	logic                    cap;
	logic                    reject;
	phase_t                  br_phase;
	logic [R_W-1:0]          br_col;
	logic signed [DEC_W-1:0] br_dec;

	// saturate diameter, radius is half rounded down
	assign diam_ext = DS_W'(diameter);
	assign dsat     = (diam_ext > DS_W'(MAX_DIAMETER)) ? DS_W'(MAX_DIAMETER) : diam_ext;
	assign r_init   = R_W'(dsat >> 1);
	assign dec_init = DEC_W'(DEC_START) - DEC_W'(dsat);

	assign col_p1  = {1'b0, col_q} + (R_W+1)'(1);
	assign col_p2  = col_p1 + (R_W+1)'(1);
	assign row_ext = {1'b0, row_q};

	assign dec_flat = dec_q + DEC_W'({col_q, 2'b00}) + DEC_W'(DEC_STEP_FLAT);
	assign dec_diag = dec_q + DEC_W'({col_q, 2'b00}) - DEC_W'({row_q, 2'b00})
		+ DEC_W'(DEC_STEP_DIAG);

	// the 64th span closes the item whatever remains
	assign cap    = &cnt_q;
	assign reject = flags.lt0 | flags.gt1;
	assign idle   = (phase_q == PH_IDLE);

	// end of the row pair: take the flat step or go on to the column pair
	always_comb begin
		br_col = col_q;
		br_dec = dec_q;
		if (dec_q[DEC_W-1]) begin
			br_dec   = dec_flat;
			br_col   = col_q + R_W'(1);
			br_phase = (col_p1 < row_ext) ? PH_LOOP_A : PH_TAIL_C;
		end else begin
			br_phase = PH_LOOP_C;
		end
	end

	// operands of the shared unit
	always_comb begin
		op   = '0;
		a0   = CALC_W'(cx_q);
		b0   = CALC_W'(row_q);
		c0   = CALC_W'(win_left);
		a1   = CALC_W'(cy_q);
		b1   = CALC_W'(col_q);
		c1   = CALC_W'(win_right);
		ofs  = col_q;
		case (phase_q)
			PH_CHK_X: begin
				a1      = CALC_W'(cx_q);
				b1      = CALC_W'(row_q);
				op.sub1 = 1'b1;
			end
			PH_CHK_Y: begin
				a0      = CALC_W'(cy_q);
				c0      = CALC_W'(win_top);
				b1      = CALC_W'(row_q);
				c1      = CALC_W'(win_bottom);
				op.sub1 = 1'b1;
			end
			PH_LOOP_A: begin
				op.sub0 = 1'b1;
				op.sub1 = 1'b1;
				ofs     = row_q;
			end
			PH_LOOP_B: begin
				op.sub0 = 1'b1;
				ofs     = row_q;
			end
			PH_LOOP_C, PH_TAIL_C: begin
				b0      = CALC_W'(col_q);
				b1      = CALC_W'(row_q);
				op.sub0 = 1'b1;
				op.sub1 = 1'b1;
			end
			PH_LOOP_D, PH_TAIL_D: begin
				b0      = CALC_W'(col_q);
				b1      = CALC_W'(row_q);
				op.sub0 = 1'b1;
			end
			default: begin
				op = '0;
			end
		endcase
	end

	assign span_width = WIDTH_W'({ofs, 1'b1});

	always_comb begin
		phase_d = phase_q;
		col_d   = col_q;
		row_d   = row_q;
		dec_d   = dec_q;
		emit    = '0;
		case (phase_q)
			PH_IDLE: begin
				if (start) begin
					phase_d = PH_CHK_X;
					col_d   = '0;
					row_d   = r_init;
					dec_d   = dec_init;
				end
			end
			PH_CHK_X: begin
				phase_d = reject ? PH_IDLE : PH_CHK_Y;
			end
			PH_CHK_Y: begin
				if (reject) begin
					phase_d = PH_IDLE;
				end else begin
					phase_d = (row_q != '0) ? PH_LOOP_A : PH_TAIL_C;
				end
			end
			PH_LOOP_A: begin
				if (slot_free) begin
					emit.load = 1'b1;
					emit.last = cap;
					if (cap) begin
						phase_d = PH_IDLE;
					end else if (col_q != '0) begin
						phase_d = PH_LOOP_B;
					end else begin
						phase_d = br_phase;
						col_d   = br_col;
						dec_d   = br_dec;
					end
				end
			end
			PH_LOOP_B: begin
				if (slot_free) begin
					emit.load = 1'b1;
					emit.last = cap;
					if (cap) begin
						phase_d = PH_IDLE;
					end else begin
						phase_d = br_phase;
						col_d   = br_col;
						dec_d   = br_dec;
					end
				end
			end
			PH_LOOP_C: begin
				if (slot_free) begin
					emit.load = 1'b1;
					emit.last = cap;
					phase_d   = cap ? PH_IDLE : PH_LOOP_D;
				end
			end
			PH_LOOP_D: begin
				if (slot_free) begin
					emit.load = 1'b1;
					emit.last = cap | (col_p2 > row_ext);
					dec_d     = dec_diag;
					col_d     = col_q + R_W'(1);
					row_d     = row_q - R_W'(1);
					if (cap) begin
						phase_d = PH_IDLE;
					end else if (col_p2 < row_ext) begin
						phase_d = PH_LOOP_A;
					end else if (col_p2 == row_ext) begin
						phase_d = PH_TAIL_C;
					end else begin
						phase_d = PH_IDLE;
					end
				end
			end
			PH_TAIL_C: begin
				if (slot_free) begin
					emit.load = 1'b1;
					emit.last = cap | (row_q == '0);
					phase_d   = (cap | (row_q == '0)) ? PH_IDLE : PH_TAIL_D;
				end
			end
			PH_TAIL_D: begin
				if (slot_free) begin
					emit.load = 1'b1;
					emit.last = 1'b1;
					phase_d   = PH_IDLE;
				end
			end
			default: begin
				phase_d = PH_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			col_q   <= '0;
			row_q   <= '0;
			dec_q   <= '0;
			cnt_q   <= '0;
			cx_q    <= '0;
			cy_q    <= '0;
		end else begin
			phase_q <= phase_d;
			col_q   <= col_d;
			row_q   <= row_d;
			dec_q   <= dec_d;
			if (start && idle) begin
				cnt_q <= '0;
				cx_q  <= center_x;
				cy_q  <= center_y;
			end else if (emit.load) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end
endmodule

/* hw/rtl/filled_circle_span_generator_core.sv */
// ----------------------------------------------------------------------------
// filled_circle_span_generator_core
// flow: a taken circle goes through the column test, then the row test, then
//   the loop loads its spans into the output register; N spans per circle
//   (N up to 64, about 2r+1), one span per cycle out of the shared lane unit
//   while the output slot is free; a rejected circle ends at the failing test
// reset: arst_n asynchronous active low, clip window returns to full range
// ----------------------------------------------------------------------------
module filled_circle_span_generator_core #(
	parameter int unsigned COORD_BITS   = fcsg_pkg::COORD_BITS_DEF,
	parameter int unsigned MAX_DIAMETER = fcsg_pkg::MAX_DIAMETER_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	fcsg_circle_if.sink                         circle,
	fcsg_span_if.source                         span,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [fcsg_pkg::APB_ADDR_W-1:0]     paddr,
	input  logic [fcsg_pkg::APB_DATA_W-1:0]     pwdata,
	output logic [fcsg_pkg::APB_DATA_W-1:0]     prdata,
	output logic                                pready
);
	import fcsg_pkg::*;

	localparam int unsigned CALC_W = calc_width(COORD_BITS);
	localparam int unsigned OUT_W  = out_width(COORD_BITS);

	// clip window registers
	logic [CLIP_W-1:0] win_left_q;
	logic [CLIP_W-1:0] win_right_q;
	logic [CLIP_W-1:0] win_top_q;
	logic [CLIP_W-1:0] win_bottom_q;
	fcsg_reg_t         reg_sel;
	logic              wr_en;

	// output register, parts the sequencer from the span consumer
	logic                    out_valid_q;
	logic signed [OUT_W-1:0] span_x_q;
	logic signed [OUT_W-1:0] span_y_q;
	logic [WIDTH_W-1:0]      span_width_q;
	logic                    last_span_q;
	logic                    slot_free;

	// sequencer <-> shared unit
	logic                     seq_idle;
	logic                     start;
	fcsg_op_t                 op;
	fcsg_flags_t              flags;
	fcsg_emit_t               emit;
	logic [WIDTH_W-1:0]       seq_width;
	logic signed [CALC_W-1:0] a0, b0, c0, a1, b1, c1, res0, res1;

	// register file: write on the access phase, reads are combinational
	assign pready  = 1'b1;
	assign reg_sel = fcsg_reg_t'(paddr[APB_ADDR_W-1:2]);
	assign wr_en   = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_left_q   <= WIN_LEFT_RST;
			win_right_q  <= WIN_RIGHT_RST;
			win_top_q    <= WIN_TOP_RST;
			win_bottom_q <= WIN_BOTTOM_RST;
		end else if (wr_en) begin
			case (reg_sel)
				REG_WIN_LEFT:   win_left_q   <= pwdata[CLIP_W-1:0];
				REG_WIN_RIGHT:  win_right_q  <= pwdata[CLIP_W-1:0];
				REG_WIN_TOP:    win_top_q    <= pwdata[CLIP_W-1:0];
				REG_WIN_BOTTOM: win_bottom_q <= pwdata[CLIP_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_WIN_LEFT:   prdata = APB_DATA_W'(win_left_q);
			REG_WIN_RIGHT:  prdata = APB_DATA_W'(win_right_q);
			REG_WIN_TOP:    prdata = APB_DATA_W'(win_top_q);
			REG_WIN_BOTTOM: prdata = APB_DATA_W'(win_bottom_q);
			default:        prdata = '0;
		endcase
	end

	// a circle is taken only while the sequencer is idle
	assign circle.ready = seq_idle;
	assign start        = circle.valid & seq_idle;

	// the sequencer may load a span when the register is empty or being drained
	assign slot_free = ~out_valid_q | span.ready;

	fcsg_seq #(
		.COORD_BITS   (COORD_BITS),
		.MAX_DIAMETER (MAX_DIAMETER)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.idle        (seq_idle),
		.center_x    (circle.center_x),
		.center_y    (circle.center_y),
		.diameter    (circle.diameter),
		.win_left    (win_left_q),
		.win_right   (win_right_q),
		.win_top     (win_top_q),
		.win_bottom  (win_bottom_q),
		.slot_free   (slot_free),
		.op          (op),
		.a0          (a0),
		.b0          (b0),
		.c0          (c0),
		.a1          (a1),
		.b1          (b1),
		.c1          (c1),
		.flags       (flags),
		.emit        (emit),
		.span_width  (seq_width)
	);

	// one adder pair does both the clip test and every span coordinate
	fcsg_lane_unit #(
		.COORD_BITS (COORD_BITS)
	) u_lane (
		.op    (op),
		.a0    (a0),
		.b0    (b0),
		.c0    (c0),
		.a1    (a1),
		.b1    (b1),
		.c1    (c1),
		.res0  (res0),
		.res1  (res1),
		.flags (flags)
	);

	// output valid: set on a load, cleared once the transaction completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit.load) begin
			out_valid_q <= 1'b1;
		end else if (span.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// span payload, coordinates wrap to the output width
	always_ff @(posedge clk) begin
		if (emit.load) begin
			span_x_q     <= res0[OUT_W-1:0];
			span_y_q     <= res1[OUT_W-1:0];
			span_width_q <= seq_width;
			last_span_q  <= emit.last;
		end
	end

	assign span.valid      = out_valid_q;
	assign span.span_x     = span_x_q;
	assign span.span_y     = span_y_q;
	assign span.span_width = span_width_q;
	assign span.last_span  = last_span_q;
endmodule

/* hw/rtl/fcsg_checker.sv */
// ----------------------------------------------------------------------------
// fcsg_checker
// port-level checks on the span generator, bound to the top level
// ----------------------------------------------------------------------------
module fcsg_checker #(
	parameter int unsigned COORD_BITS = fcsg_pkg::COORD_BITS_DEF
) (
	input logic                                      clk,
	input logic                                      arst_n,
	input logic                                      in_valid,
	input logic                                      in_ready,
	input logic                                      out_valid,
	input logic                                      out_ready,
	input logic                                      out_last,
	input logic [fcsg_pkg::out_width(COORD_BITS)-1:0] out_x,
	input logic [fcsg_pkg::out_width(COORD_BITS)-1:0] out_y,
	input logic [fcsg_pkg::WIDTH_W-1:0]              out_width
);
	import fcsg_pkg::*;

	// a circle keeps the block busy for at least the column test
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("block ready right after taking a circle");

	// while idle, any span still waiting must be the final one of its circle
	a_idle_only_last: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready && out_valid |-> out_last)
		else $error("idle with an unfinished circle on the output");

	// no span of a new circle before the clip test has run
	a_no_early_span: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> (!out_valid || out_last) ##1 (!out_valid || out_last))
		else $error("span of a new circle before the clip test finished");

	// a stalled span holds
	a_span_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(out_y)
			&& $stable(out_width) && $stable(out_last))
		else $error("stalled span changed");
endmodule

bind filled_circle_span_generator_core fcsg_checker #(
	.COORD_BITS (COORD_BITS)
) u_fcsg_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (circle.valid),
	.in_ready  (circle.ready),
	.out_valid (span.valid),
	.out_ready (span.ready),
	.out_last  (span.last_span),
	.out_x     (span.span_x),
	.out_y     (span.span_y),
	.out_width (span.span_width)
);

/* tb/sv/tb_filled_circle_span_generator_core.sv */
// ----------------------------------------------------------------------------
// tb_filled_circle_span_generator_core
// self-checking bench for the filled circle span generator: circles go in over
// the circle channel, every span coming out is compared field by field with an
// in-bench midpoint-loop predictor, under a series of clip windows set over apb
// ----------------------------------------------------------------------------
module tb_filled_circle_span_generator_core;
	timeunit 1ns;
	timeprecision 1ps;

	import fcsg_pkg::*;

	localparam int unsigned COORD_BITS   = COORD_BITS_DEF;
	localparam int unsigned MAX_DIAMETER = MAX_DIAMETER_DEF;
	localparam int unsigned OUT_W        = out_width(COORD_BITS);

	localparam time CLK_PERIOD = 10ns;
	localparam time RUN_LIMIT  = 5ms;

	// cycles to let a rejected circle clear the block before touching the window
	localparam int SETTLE_CYCLES = 10;
	localparam int DRAIN_LIMIT   = 20000;
	localparam int RANDOM_PER_WINDOW = 25;
	localparam int HOLD_CYCLES   = 400;

	// one expected span as it should leave the block
	typedef struct {
		logic signed [OUT_W-1:0] x;
		logic signed [OUT_W-1:0] y;
		logic [WIDTH_W-1:0]      w;
		logic                    last;
	} span_t;

	logic clk = 1'b0;
	logic arst_n;

	fcsg_circle_if #(.COORD_BITS(COORD_BITS)) circle_bus ();
	fcsg_span_if   #(.COORD_BITS(COORD_BITS)) span_bus ();

	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	// bench copy of the clip window
	logic [CLIP_W-1:0] win_left;
	logic [CLIP_W-1:0] win_right;
	logic [CLIP_W-1:0] win_top;
	logic [CLIP_W-1:0] win_bottom;

	// spans predicted but not yet seen, oldest first
	span_t pending_spans[$];

	int mismatch_count   = 0;
	int circles_sent     = 0;
	int circles_rejected = 0;
	int spans_checked    = 0;
	int windows_used     = 0;

	// random idling on both channels, switched off for the no-gap stretch
	bit idle_on = 1'b1;

	// long receiver hold: the test bumps the sequence, the receiver counts it out
	int rx_hold_len  = 0;
	int rx_hold_seq  = 0;
	int rx_hold_seen = 0;
	int rx_hold_left = 0;

	filled_circle_span_generator_core #(
		.COORD_BITS  (COORD_BITS),
		.MAX_DIAMETER(MAX_DIAMETER)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.circle (circle_bus.sink),
		.span   (span_bus.source),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	task automatic report_mismatch(input string what);
		$display("mismatch at %0t: %s", $realtime, what);
		mismatch_count++;
	endtask

	// ------------------------------------------------------------------------
	// predictor
	// ------------------------------------------------------------------------

	function automatic void queue_span(input int x, input int y, input int w, ref int count);
		span_t s;
		if (count >= MAX_SPANS) begin
			return;
		end
		s.x = OUT_W'(x);
		s.y = OUT_W'(y);
		s.w = WIDTH_W'(w);
		s.last = 1'b0;
		pending_spans.push_back(s);
		count++;
	endfunction

	// midpoint loop over the circle; returns the number of spans queued
	function automatic int plan_circle_spans(input logic signed [COORD_BITS-1:0] cx_in,
		input logic signed [COORD_BITS-1:0] cy_in, input logic [DIAM_W-1:0] d_in);
		int cx;
		int cy;
		int d;
		int rad;
		int p;
		int col;
		int row;
		int count;
		cx = cx_in;
		cy = cy_in;
		d = int'(d_in);
		count = 0;
		// diameter saturates, radius rounds down
		if (d > MAX_DIAMETER) begin
			d = MAX_DIAMETER;
		end
		rad = d / 2;

		// bounding box wholly outside the window: nothing comes out
		if (cx + rad < int'(win_left)) return 0;
		if (cx - rad > int'(win_right)) return 0;
		if (cy + rad < int'(win_top)) return 0;
		if (cy - rad > int'(win_bottom)) return 0;

		p = int'(DEC_START) - d;
		col = 0;
		row = rad;
		while (col < row) begin
			queue_span(cx - row, cy - col, row * 2 + 1, count);
			if (col != 0) begin
				queue_span(cx - row, cy + col, row * 2 + 1, count);
			end
			if (p < 0) begin
				p = p + col * 4 + int'(DEC_STEP_FLAT);
			end else begin
				queue_span(cx - col, cy - row, col * 2 + 1, count);
				if (row != 0) begin
					queue_span(cx - col, cy + row, col * 2 + 1, count);
				end
				p = p + (col - row) * 4 + int'(DEC_STEP_DIAG);
				row--;
			end
			col++;
		end
		if (col == row) begin
			queue_span(cx - col, cy - row, col * 2 + 1, count);
			if (row != 0) begin
				queue_span(cx - col, cy + row, col * 2 + 1, count);
			end
		end
		if (count > 0) begin
			pending_spans[pending_spans.size() - 1].last = 1'b1;
		end
		return count;
	endfunction

	// ------------------------------------------------------------------------
	// span receiver: random ready, plus a long counted hold on request
	// ------------------------------------------------------------------------
	initial begin
		span_bus.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (rx_hold_seq != rx_hold_seen) begin
				rx_hold_seen = rx_hold_seq;
				rx_hold_left = rx_hold_len;
			end
			if (rx_hold_left > 0) begin
				rx_hold_left--;
				span_bus.ready <= 1'b0;
			end else if (idle_on) begin
				span_bus.ready <= ($urandom_range(0, 99) >= 25);
			end else begin
				span_bus.ready <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------------
	// span checker: every accepted span against the oldest prediction
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : span_check
		span_t want;
		if (arst_n && span_bus.valid && span_bus.ready) begin
			if (pending_spans.size() == 0) begin
				report_mismatch($sformatf("span x %0d y %0d with no span expected",
					span_bus.span_x, span_bus.span_y));
			end else begin
				want = pending_spans.pop_front();
				if (span_bus.span_x !== want.x)
					report_mismatch($sformatf("span %0d x got %0d want %0d",
						spans_checked, span_bus.span_x, want.x));
				if (span_bus.span_y !== want.y)
					report_mismatch($sformatf("span %0d y got %0d want %0d",
						spans_checked, span_bus.span_y, want.y));
				if (span_bus.span_width !== want.w)
					report_mismatch($sformatf("span %0d width got %0d want %0d",
						spans_checked, span_bus.span_width, want.w));
				if (span_bus.last_span !== want.last)
					report_mismatch($sformatf("span %0d last got %0b want %0b",
						spans_checked, span_bus.last_span, want.last));
			end
			spans_checked++;
		end
	end

	// ------------------------------------------------------------------------
	// circle sender and channel helpers
	// ------------------------------------------------------------------------

	// offers one circle, waits for its transaction and predicts its spans
	task automatic send_circle(input logic signed [COORD_BITS-1:0] cx,
		input logic signed [COORD_BITS-1:0] cy, input logic [DIAM_W-1:0] d);
		while (idle_on && $urandom_range(0, 99) < 25) begin
			circle_bus.valid <= 1'b0;
			@(posedge clk);
		end
		circle_bus.valid    <= 1'b1;
		circle_bus.center_x <= cx;
		circle_bus.center_y <= cy;
		circle_bus.diameter <= d;
		@(posedge clk);
		while (!circle_bus.ready) begin
			@(posedge clk);
		end
		circles_sent++;
		if (plan_circle_spans(cx, cy, d) == 0) begin
			circles_rejected++;
		end
	endtask

	task automatic circle_idle();
		circle_bus.valid <= 1'b0;
	endtask

	// wait out every predicted span, then let a trailing rejected circle clear
	task automatic wait_for_spans();
		int waited;
		waited = 0;
		while (pending_spans.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		if (pending_spans.size() != 0) begin
			report_mismatch($sformatf("%0d spans never arrived", pending_spans.size()));
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// ------------------------------------------------------------------------
	// apb: write one clip register, then read it straight back
	// ------------------------------------------------------------------------
	task automatic write_clip(input fcsg_reg_t idx, input logic [CLIP_W-1:0] val);
		logic [APB_DATA_W-1:0] got;
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= APB_DATA_W'(val);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		// register written at this edge; go straight into the read-back setup
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_WIN_LEFT:   win_left   = val;
			REG_WIN_RIGHT:  win_right  = val;
			REG_WIN_TOP:    win_top    = val;
			REG_WIN_BOTTOM: win_bottom = val;
			default: ;
		endcase
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		got = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		if (got !== APB_DATA_W'(val)) begin
			report_mismatch($sformatf("register %s read back %0d want %0d",
				idx.name(), got, val));
		end
	endtask

	task automatic set_window(input logic [CLIP_W-1:0] l, input logic [CLIP_W-1:0] r,
		input logic [CLIP_W-1:0] t, input logic [CLIP_W-1:0] b);
		write_clip(REG_WIN_LEFT, l);
		write_clip(REG_WIN_RIGHT, r);
		write_clip(REG_WIN_TOP, t);
		write_clip(REG_WIN_BOTTOM, b);
		windows_used++;
	endtask

	// ------------------------------------------------------------------------
	// random circles
	// ------------------------------------------------------------------------

	// uniform pick in [lo, hi] after clamping to the centre range
	function automatic logic signed [COORD_BITS-1:0] pick_coord(input int lo, input int hi);
		if (lo < -4096) lo = -4096;
		if (hi > 4095) hi = 4095;
		if (hi < lo) hi = lo;
		return COORD_BITS'(lo + int'($urandom_range(0, hi - lo)));
	endfunction

	// mostly circles around the window, some anywhere, some on a window edge
	task automatic send_random_circle();
		logic [DIAM_W-1:0] d;
		int rad;
		int xlo;
		int xhi;
		int ylo;
		int yhi;
		int kind;
		logic signed [COORD_BITS-1:0] cx;
		logic signed [COORD_BITS-1:0] cy;
		d = DIAM_W'($urandom_range(0, 63));
		rad = (int'(d) > MAX_DIAMETER ? MAX_DIAMETER : int'(d)) / 2;
		xlo = (win_left < win_right) ? int'(win_left) : int'(win_right);
		xhi = (win_left < win_right) ? int'(win_right) : int'(win_left);
		ylo = (win_top < win_bottom) ? int'(win_top) : int'(win_bottom);
		yhi = (win_top < win_bottom) ? int'(win_bottom) : int'(win_top);
		kind = $urandom_range(0, 99);
		if (kind < 65) begin
			cx = pick_coord(xlo - rad - 4, xhi + rad + 4);
			cy = pick_coord(ylo - rad - 4, yhi + rad + 4);
		end else if (kind < 85) begin
			cx = COORD_BITS'($urandom());
			cy = COORD_BITS'($urandom());
		end else begin
			cx = pick_coord(xlo, xhi);
			cy = pick_coord(ylo, yhi);
			case ($urandom_range(0, 3))
				0: cx = pick_coord(int'(win_left) - rad - 2, int'(win_left) - rad + 2);
				1: cx = pick_coord(int'(win_right) + rad - 2, int'(win_right) + rad + 2);
				2: cy = pick_coord(int'(win_top) - rad - 2, int'(win_top) - rad + 2);
				default: cy = pick_coord(int'(win_bottom) + rad - 2, int'(win_bottom) + rad + 2);
			endcase
		end
		send_circle(cx, cy, d);
	endtask

	// ------------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------------

	// reset window: size extremes, saturation, corners of the coordinate range
	task automatic test_reset_window();
		send_circle(13'sd0, 13'sd0, 6'd0);
		send_circle(13'sd0, 13'sd0, 6'd1);
		send_circle(13'sd0, 13'sd0, 6'd2);
		send_circle(13'sd2048, 13'sd2048, 6'd62);
		// diameter above the maximum saturates
		send_circle(13'sd2048, 13'sd2048, 6'd63);
		send_circle(13'sd100, 13'sd100, 6'd3);
		send_circle(13'sd100, 13'sd100, 6'd5);
		send_circle(13'sd4095, 13'sd4095, 6'd62);
		// box just touching the top-left corner of the window
		send_circle(-13'sd31, -13'sd31, 6'd62);
		// one column further out: rejected
		send_circle(-13'sd32, 13'sd0, 6'd62);
		send_circle(-13'sd4096, -13'sd4096, 6'd63);
		send_circle(13'sh0AAA, 13'sh0555, 6'h2A);
		send_circle(13'sh1555, 13'sh1AAA, 6'h15);
		circle_idle();
		wait_for_spans();
	endtask

	// boxes exactly on and one past each edge of a narrow window
	task automatic test_clip_edges();
		set_window(12'd1000, 12'd1100, 12'd2000, 12'd2100);
		send_circle(13'sd990, 13'sd2050, 6'd20);
		send_circle(13'sd989, 13'sd2050, 6'd20);
		send_circle(13'sd1110, 13'sd2050, 6'd20);
		send_circle(13'sd1111, 13'sd2050, 6'd20);
		send_circle(13'sd1050, 13'sd1990, 6'd21);
		send_circle(13'sd1050, 13'sd1989, 6'd21);
		send_circle(13'sd1050, 13'sd2110, 6'd21);
		send_circle(13'sd1050, 13'sd2111, 6'd21);
		circle_idle();
		wait_for_spans();
	endtask

	task automatic run_random_phase(input logic [CLIP_W-1:0] l, input logic [CLIP_W-1:0] r,
		input logic [CLIP_W-1:0] t, input logic [CLIP_W-1:0] b);
		set_window(l, r, t, b);
		repeat (RANDOM_PER_WINDOW) send_random_circle();
		circle_idle();
		wait_for_spans();
	endtask

	// full, small, degenerate at both ends, inverted and random windows
	task automatic test_random_windows();
		run_random_phase(12'd0, 12'd4095, 12'd0, 12'd4095);
		run_random_phase(12'd100, 12'd300, 12'd50, 12'd200);
		run_random_phase(12'd4095, 12'd4095, 12'd4095, 12'd4095);
		run_random_phase(12'd0, 12'd0, 12'd0, 12'd0);
		// inverted: no special handling, the four tests still apply
		run_random_phase(12'd3000, 12'd1000, 12'd2500, 12'd500);
		repeat (2) begin
			run_random_phase(CLIP_W'($urandom()), CLIP_W'($urandom()),
				CLIP_W'($urandom()), CLIP_W'($urandom()));
		end
	endtask

	// receiver held off for a long stretch while big circles keep coming,
	// with no idling anywhere, so the block backs up onto its input
	task automatic test_backpressure();
		set_window(12'd0, 12'd4095, 12'd0, 12'd4095);
		idle_on = 1'b0;
		rx_hold_len = HOLD_CYCLES;
		rx_hold_seq++;
		repeat (18) begin
			send_circle(pick_coord(200, 3800), pick_coord(200, 3800),
				DIAM_W'($urandom_range(40, 63)));
		end
		circle_idle();
		wait_for_spans();
		idle_on = 1'b1;
	endtask

	// sender stops until every span is out, then carries on
	task automatic test_sender_pause();
		set_window(12'd500, 12'd700, 12'd500, 12'd700);
		repeat (8) send_random_circle();
		circle_idle();
		wait_for_spans();
		repeat (8) send_random_circle();
		circle_idle();
		wait_for_spans();
	endtask

	// ------------------------------------------------------------------------
	// sequence
	// ------------------------------------------------------------------------
	initial begin
		arst_n              = 1'b0;
		circle_bus.valid    = 1'b0;
		circle_bus.center_x = '0;
		circle_bus.center_y = '0;
		circle_bus.diameter = '0;
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
		paddr   = '0;
		pwdata  = '0;
		win_left   = WIN_LEFT_RST;
		win_right  = WIN_RIGHT_RST;
		win_top    = WIN_TOP_RST;
		win_bottom = WIN_BOTTOM_RST;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_window();
		test_clip_edges();
		test_random_windows();
		test_backpressure();
		test_sender_pause();

		$display("run covered %0d circles (%0d rejected) and %0d spans", circles_sent,
			circles_rejected, spans_checked);
		$display("over %0d clip windows including inverted and degenerate ones, with back-pressure",
			windows_used + 1);
		if (mismatch_count == 0) begin
			$display("filled_circle_span_generator_core test passed");
		end else begin
			$display("filled_circle_span_generator_core test failed");
		end
		$finish;
	end

	// watchdog
	initial begin
		#(RUN_LIMIT);
		$display("timeout with %0d spans outstanding", pending_spans.size());
		$display("filled_circle_span_generator_core test failed");
		$finish;
	end

endmodule

/* filled_circle_span_generator_core.f */
hw/rtl/fcsg_pkg.sv
hw/rtl/fcsg_circle_if.sv
hw/rtl/fcsg_span_if.sv
hw/rtl/fcsg_lane_unit.sv
hw/rtl/fcsg_seq.sv
hw/rtl/filled_circle_span_generator_core.sv
hw/rtl/fcsg_checker.sv
tb/sv/tb_filled_circle_span_generator_core.sv
